>>> rtl/icv_pkg.sv
package icv_pkg;

	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

	localparam logic [1:0] ST_MATCH    = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_SIZE_ERR = 2'd2;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_START = 1'b1;

	localparam logic REG_IMAGE_LENGTH    = 1'b0;
	localparam logic REG_STORED_CHECKSUM = 1'b1;

	// one classified input word on its way to the CRC engine
	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] checksum;
		logic [31:0] echo;
	} res_t;

	// reflected CRC-32, one byte folded in per call
	function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/icv_front.sv
module icv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	output logic          full,
	output logic          cmd_valid,
	output icv_pkg::cmd_t cmd,
	input  logic          cmd_ready
);
	import icv_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       pop_ok;
	cmd_t       cmd_in;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_valid && cmd_ready;

	always_comb begin
		cmd_in.start = (kind == KIND_START);
		cmd_in.data  = data_byte;
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
		end
	end

endmodule

>>> rtl/icv_back.sv
module icv_back #(
	parameter int REGION_BYTES = 131072
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   image_length,
	input  logic [31:0]   stored_checksum,
	input  logic          cmd_valid,
	input  icv_pkg::cmd_t cmd,
	output logic          cmd_ready,
	output logic          res_push,
	output icv_pkg::res_t res,
	input  logic          res_ready
);
	import icv_pkg::*;

	localparam int          CNT_W    = $clog2(REGION_BYTES + 1);
	localparam logic [31:0] REGION_W = 32'(REGION_BYTES);

	logic [31:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             armed_q;
	logic             take;
	logic             size_bad;
	logic [31:0]      crc_next;
	logic [CNT_W-1:0] cnt_next;
	logic             done;
	logic [31:0]      final_crc;

	assign cmd_ready = res_ready;
	assign take      = cmd_valid && res_ready;
	assign size_bad  = (image_length == 32'd0) || (image_length > REGION_W);
	assign crc_next  = crc_fold_byte(crc_q, cmd.data);
	assign cnt_next  = cnt_q + CNT_W'(1);
	assign done      = ({{(32-CNT_W){1'b0}}, cnt_next} >= image_length) ||
	                   ({{(32-CNT_W){1'b0}}, cnt_next} >= REGION_W);
	assign final_crc = crc_next ^ CRC_ALL_ONES;

	always_comb begin
		res_push     = 1'b0;
		res.status   = ST_MATCH;
		res.checksum = 32'd0;
		res.echo     = stored_checksum;
		if (take) begin
			if (cmd.start) begin
				if (size_bad) begin
					res_push   = 1'b1;
					res.status = ST_SIZE_ERR;
				end
			end else if (armed_q && done) begin
				res_push     = 1'b1;
				res.checksum = final_crc;
				res.status   = (final_crc == stored_checksum) ? ST_MATCH : ST_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_ALL_ONES;
			cnt_q   <= '0;
			armed_q <= 1'b0;
		end else if (take) begin
			if (cmd.start) begin
				crc_q   <= CRC_ALL_ONES;
				cnt_q   <= '0;
				armed_q <= !size_bad;
			end else if (armed_q) begin
				crc_q <= crc_next;
				cnt_q <= cnt_next;
				// drop back to idle once the image is complete
				if (done) begin
					armed_q <= 1'b0;
				end
			end
		end
	end

	a_size_err: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.start && size_bad |-> res_push && res.status == ST_SIZE_ERR)
		else $error("size error not reported");

	a_push_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> take)
		else $error("result without a consumed word");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !armed_q)
		else $error("still armed after a result");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> {{(32-CNT_W){1'b0}}, cnt_q} < REGION_W)
		else $error("byte count past region size");

endmodule

>>> rtl/icv_res_queue.sv
module icv_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  icv_pkg::res_t res,
	output logic          res_ready,
	output logic          empty,
	input  logic          pop,
	output icv_pkg::res_t head
);
	import icv_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       pop_ok;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign head      = ent_q[rd_ptr_q];
	assign push_ok   = res_push && res_ready;
	assign pop_ok    = pop && !empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
		end
	end

endmodule

>>> rtl/image_crc32_verifier.sv
// Firmware image CRC-32 check (reflected, polynomial EDB88320).
// Input channel: a word (kind, data_byte) is taken when push is high and full
// is low. kind = start clears the CRC and byte count and checks image_length;
// kind = data folds one byte into the CRC while a check is armed, and is
// dropped otherwise.
// Result channel: the oldest result sits on status / computed_checksum /
// expected_echo while empty is low; pop takes it.
// Configuration: cfg_we writes cfg_data into image_length (index 0) or
// stored_checksum (index 1); write only while no word is in flight.
// Throughput: one word per cycle while the result queue has room, set by the
// combinational byte CRC update in the back end. A word is stored in a two-entry
// input queue, taken from there by the back end, and its result is written into
// the result queue, from which pop takes it.
// When pop is held low the two-entry result queue fills, then the CRC engine
// holds, then the input queue fills and full rises; nothing is lost.
// Reset clears both queues, the registers to zero, and leaves the block idle
// with the CRC at all ones.
module image_crc32_verifier #(
	parameter int REGION_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] computed_checksum,
	output logic [31:0] expected_echo,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import icv_pkg::*;

	logic [31:0] image_length_q;
	logic [31:0] stored_checksum_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        res_push;
	logic        res_ready;
	res_t        res;
	res_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q    <= 32'd0;
			stored_checksum_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_LENGTH:    image_length_q    <= cfg_data;
				REG_STORED_CHECKSUM: stored_checksum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	icv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.kind      (kind),
		.data_byte (data_byte),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	icv_back #(
		.REGION_BYTES (REGION_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.image_length    (image_length_q),
		.stored_checksum (stored_checksum_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_ready       (cmd_ready),
		.res_push        (res_push),
		.res             (res),
		.res_ready       (res_ready)
	);

	icv_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign status            = head.status;
	assign computed_checksum = head.checksum;
	assign expected_echo     = head.echo;

endmodule

>>> dv/image_crc32_verifier_checker.sv
`timescale 1ns / 100ps

module image_crc32_verifier_checker #(
	parameter int REGION_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [31:0] computed_checksum,
	input  logic [31:0] expected_echo,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          failures,
	output int          pending,
	output int          match_count,
	output int          mismatches,
	output int          size_errors,
	output logic [31:0] last_final
);
	import icv_pkg::*;

	res_t        verdict_q[$];
	res_t        want;
	logic [31:0] img_len;
	logic [31:0] stored_sum;
	logic [31:0] crc_run;
	logic [31:0] taken;
	logic        armed;

	// bit-serial form of the reflected update, LSB of the byte first
	function automatic logic [31:0] crc32_fold_octet(input logic [31:0] crc,
			input logic [7:0] octet);
		logic [31:0] c;
		logic        fb;
		int          i;
		c = crc;
		for (i = 0; i < 8; i++) begin
			fb = c[0] ^ octet[i];
			c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
		end
		return c;
	endfunction

	task automatic predict_verdict(input logic k, input logic [7:0] b);
		logic [31:0] fin;
		if (k == KIND_START) begin
			crc_run = CRC_ALL_ONES;
			taken = '0;
			if (img_len == 32'h0 || img_len > 32'(REGION_BYTES)) begin
				armed = 1'b0;
				verdict_q.push_back(res_t'{status: ST_SIZE_ERR, checksum: 32'h0,
					echo: stored_sum});
			end else begin
				armed = 1'b1;
			end
		end else if (armed) begin
			crc_run = crc32_fold_octet(crc_run, b);
			taken = taken + 32'd1;
			if (taken >= img_len || taken >= 32'(REGION_BYTES)) begin
				armed = 1'b0;
				fin = ~crc_run;
				last_final = fin;
				verdict_q.push_back(res_t'{
					status: (fin == stored_sum) ? ST_MATCH : ST_MISMATCH,
					checksum: fin, echo: stored_sum});
			end
		end
	endtask

	task automatic compare_word(input res_t exp_w);
		if (status !== exp_w.status) begin
			$error("status: expected %0d, got %0d", exp_w.status, status);
			failures++;
		end
		if (computed_checksum !== exp_w.checksum) begin
			$error("computed_checksum: expected %08h, got %08h", exp_w.checksum,
				computed_checksum);
			failures++;
		end
		if (expected_echo !== exp_w.echo) begin
			$error("expected_echo: expected %08h, got %08h", exp_w.echo, expected_echo);
			failures++;
		end
		case (exp_w.status)
			ST_MATCH:    match_count++;
			ST_MISMATCH: mismatches++;
			default:     size_errors++;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_len = '0;
			stored_sum = '0;
			crc_run = CRC_ALL_ONES;
			taken = '0;
			armed = 1'b0;
			last_final = '0;
			verdict_q.delete();
			failures = 0;
			pending = 0;
			match_count = 0;
			mismatches = 0;
			size_errors = 0;
		end else begin
			// retire the output word before predicting the new input word
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					$error("result word with nothing expected: status %0d, checksum %08h",
						status, computed_checksum);
					failures++;
				end else begin
					want = verdict_q.pop_front();
					compare_word(want);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_LENGTH:    img_len = cfg_data;
					REG_STORED_CHECKSUM: stored_sum = cfg_data;
				endcase
			end
			if (push && !full)
				predict_verdict(kind, data_byte);
			pending = verdict_q.size();
		end
	end

endmodule

>>> dv/image_crc32_verifier_test.sv
`timescale 1ns / 100ps

module image_crc32_verifier_test;
	import icv_pkg::*;

	localparam int REGION      = 131072;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_WORDS = 180;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        kind = KIND_DATA;
	logic [7:0]  data_byte = 8'h0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [31:0] computed_checksum;
	logic [31:0] expected_echo;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_IMAGE_LENGTH;
	logic [31:0] cfg_data = 32'h0;

	int          failures;
	int          pending;
	int          match_count;
	int          mismatches;
	int          size_errors;
	logic [31:0] last_final;

	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_req = 1'b0;
	int          sent = 0;
	logic [7:0]  image_q[$];

	image_crc32_verifier #(.REGION_BYTES(REGION)) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.kind              (kind),
		.data_byte         (data_byte),
		.empty             (empty),
		.pop               (pop),
		.status            (status),
		.computed_checksum (computed_checksum),
		.expected_echo     (expected_echo),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	image_crc32_verifier_checker #(.REGION_BYTES(REGION)) crc_watch (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.kind              (kind),
		.data_byte         (data_byte),
		.empty             (empty),
		.pop               (pop),
		.status            (status),
		.computed_checksum (computed_checksum),
		.expected_echo     (expected_echo),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.failures          (failures),
		.pending           (pending),
		.match_count       (match_count),
		.mismatches        (mismatches),
		.size_errors       (size_errors),
		.last_final        (last_final)
	);

	always #6 clk = ~clk;

	initial begin
		#30_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, plus one long hold when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	// called at a falling edge; returns at a falling edge with push still high
	task automatic put_word(input logic k, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			kind <= 1'($urandom);
			data_byte <= 8'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (full);
		@(negedge clk);
		sent++;
	endtask

	// drain every expected word, then give the pipeline time to go quiet
	task automatic settle();
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_image(input int n);
		logic [7:0] b;
		image_q.delete();
		put_word(KIND_START, 8'($urandom));
		repeat (n) begin
			b = 8'($urandom);
			image_q.push_back(b);
			put_word(KIND_DATA, b);
		end
	endtask

	task automatic resend_image();
		put_word(KIND_START, 8'($urandom));
		foreach (image_q[i]) put_word(KIND_DATA, image_q[i]);
	endtask

	// bytes while idle are dropped and do not count as stimulus
	task automatic stray_bytes(input int n);
		repeat (n) put_word(KIND_DATA, 8'($urandom));
		sent -= n;
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 12);
		else if (r < 95)
			return $urandom_range(13, 64);
		return $urandom_range(65, 300);
	endfunction

	function automatic logic [31:0] bad_length();
		case ($urandom_range(3))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'(REGION + 1 + $urandom_range(0, 1000));
			default: return $urandom | 32'h0004_0000;
		endcase
	endfunction

	task automatic one_check();
		int r;
		int n;
		int k;
		int m;
		r = $urandom_range(99);
		if (r < 55) begin
			n = pick_length();
			settle();
			write_reg(REG_IMAGE_LENGTH, n);
			write_reg(REG_STORED_CHECKSUM, $urandom);
			send_image(n);
			// replay the same image against its own checksum
			if ($urandom_range(99) < 40) begin
				settle();
				write_reg(REG_STORED_CHECKSUM, last_final);
				resend_image();
			end
		end else if (r < 67) begin
			settle();
			write_reg(REG_IMAGE_LENGTH, bad_length());
			if ($urandom_range(1))
				write_reg(REG_STORED_CHECKSUM, $urandom);
			put_word(KIND_START, 8'($urandom));
			stray_bytes($urandom_range(0, 3));
		end else if (r < 82) begin
			// abandon a check part way and start over
			n = pick_length() + 1;
			settle();
			write_reg(REG_IMAGE_LENGTH, n);
			put_word(KIND_START, 8'($urandom));
			repeat ($urandom_range(0, n - 1)) put_word(KIND_DATA, 8'($urandom));
			send_image(n);
		end else if (r < 92) begin
			// rewrite the length while a check is armed
			n = pick_length() + 1;
			k = $urandom_range(1, n - 1);
			settle();
			write_reg(REG_IMAGE_LENGTH, n);
			put_word(KIND_START, 8'($urandom));
			repeat (k) put_word(KIND_DATA, 8'($urandom));
			settle();
			m = $urandom_range(1, n + 4);
			write_reg(REG_IMAGE_LENGTH, m);
			repeat ((m > k) ? (m - k) : 1) put_word(KIND_DATA, 8'($urandom));
		end else begin
			stray_bytes($urandom_range(1, 4));
		end
	endtask

	// hold the result side and keep pushing until the input side backs up
	task automatic squeeze();
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'd1);
		hold_req = 1'b1;
		repeat (24) begin
			put_word(KIND_START, 8'($urandom));
			put_word(KIND_DATA, 8'($urandom));
		end
	endtask

	task automatic directed();
		int i;
		put_word(KIND_DATA, 8'h5A);
		put_word(KIND_START, 8'hFF);
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_STORED_CHECKSUM, 32'hFFFF_FFFF);
		put_word(KIND_START, 8'h00);
		put_word(KIND_DATA, 8'hFF);
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'(REGION + 1));
		put_word(KIND_START, 8'h00);
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'd9);
		write_reg(REG_STORED_CHECKSUM, 32'hCBF4_3926);
		put_word(KIND_START, 8'h00);
		for (i = 1; i <= 9; i++) put_word(KIND_DATA, 8'h30 + 8'(i));
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'd1);
		write_reg(REG_STORED_CHECKSUM, 32'h0);
		put_word(KIND_START, 8'hAA);
		put_word(KIND_DATA, 8'h00);
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'd6);
		put_word(KIND_START, 8'h00);
		put_word(KIND_DATA, 8'hFF);
		put_word(KIND_DATA, 8'h80);
		put_word(KIND_START, 8'h55);
		repeat (3) put_word(KIND_DATA, 8'h01);
		settle();
		write_reg(REG_IMAGE_LENGTH, 32'd2);
		put_word(KIND_DATA, 8'h7F);
	endtask

	initial begin
		int target;
		int p;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed();
		for (p = 0; p < 4; p++) begin
			case (p)
				0:       begin send_idle = 0;  recv_stall = 0;  end
				1:       begin send_idle = 55; recv_stall = 0;  end
				2:       begin send_idle = 0;  recv_stall = 55; end
				default: begin send_idle = 23; recv_stall = 23; end
			endcase
			target = sent + PHASE_WORDS;
			while (sent < target) one_check();
			if (p == 0)
				squeeze();
		end
		// drain the last checks
		settle();
		repeat (8) @(negedge clk);
		$display("Covered %0d checks (%0d match, %0d mismatch, %0d size error) from %0d words,",
			match_count + mismatches + size_errors, match_count, mismatches, size_errors,
			sent);
		$display("under idle/stall mixes, input backpressure, restarts and length rewrites.");
		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> image_crc32_verifier.f
rtl/icv_pkg.sv
rtl/icv_front.sv
rtl/icv_back.sv
rtl/icv_res_queue.sv
rtl/image_crc32_verifier.sv
dv/image_crc32_verifier_checker.sv
dv/image_crc32_verifier_test.sv
